// ===== src/qed_pkg.sv =====
// ----------------------------------------------------------------------------
// qed_pkg: shared types and constants for the quadrature pattern decoder
// Pattern decode table, codes, and the structs passed between blocks.
// ----------------------------------------------------------------------------
package qed_pkg;

  // configuration register indexes
  localparam logic CfgEnable    = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  localparam logic       EnableReset    = 1'b1;
  localparam logic [7:0] ThresholdReset = 8'd2;

  // previous-sample register: both high at reset, 3'b111 means "none"
  localparam logic [2:0] PairReset = 3'b011;
  localparam logic [2:0] NoPair    = 3'b111;

  localparam logic [7:0] CountMax       = 8'hff;
  localparam logic [2:0] PairsPerPattern = 3'd4;

  localparam logic signed [1:0] DirBack = -2'sd1;
  localparam logic signed [1:0] DirFwd  = 2'sd1;
  localparam logic signed [1:0] DirNone = 2'sd0;

  localparam int unsigned OutDepth = 2;

  typedef struct packed {
    logic       enable;
    logic [7:0] threshold;
  } qed_cfg_t;

  typedef struct packed {
    logic              valid;
    logic signed [1:0] direction;
  } qed_res_t;

  function automatic logic signed [1:0] decode_pattern(input logic [7:0] p);
    logic signed [1:0] d;
    case (p)
      8'h4b, 8'h2c, 8'hb4, 8'hc2: d = DirBack;
      8'h1e, 8'h78, 8'he1, 8'h87: d = DirFwd;
      default:                    d = DirNone;
    endcase
    return d;
  endfunction

endpackage

// ===== src/qed_core.sv =====
// ----------------------------------------------------------------------------
// qed_core: input register, debounce state and pattern decode
// One sample per cycle while the result buffer is not full; the state update and decode sit behind the input reg.
// ----------------------------------------------------------------------------
module qed_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qed_pkg::qed_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              chan_a_i,
  input  logic              chan_b_i,
  input  logic              out_full_i,
  output qed_pkg::qed_res_t res_o
);

  logic       in_valid_q;
  logic [1:0] pair_q;

  logic [2:0] last_q, last_d;
  logic [7:0] cnt_q, cnt_d;
  logic       chg_q, chg_d;
  logic [2:0] pc_q, pc_d;
  logic [7:0] pat_q, pat_d;

  logic       advance, update, same, take, done;
  logic [7:0] cnt_upd;
  logic       chg_upd;
  logic [2:0] pc_inc;
  logic [7:0] pat_upd;

  assign advance    = !out_full_i;
  assign in_ready_o = !in_valid_q || advance;
  assign update     = in_valid_q && advance && cfg_i.enable;

  always_comb begin
    same    = ({1'b0, pair_q} == last_q);
    cnt_upd = same ? ((cnt_q == qed_pkg::CountMax) ? cnt_q : cnt_q + 8'd1) : 8'd0;
    chg_upd = same ? chg_q : 1'b1;
    take    = (cnt_upd == cfg_i.threshold) && chg_upd;
    pc_inc  = pc_q + 3'd1;
    pat_upd = {pat_q[5:0], pair_q};
    done    = take && (pc_inc == qed_pkg::PairsPerPattern);

    last_d = last_q;
    cnt_d  = cnt_q;
    chg_d  = chg_q;
    pc_d   = pc_q;
    pat_d  = pat_q;
    if (update) begin
      last_d = {1'b0, pair_q};
      cnt_d  = cnt_upd;
      chg_d  = take ? 1'b0 : chg_upd;
      pc_d   = take ? pc_inc : pc_q;
      pat_d  = take ? pat_upd : pat_q;
      if (done) begin
        last_d = qed_pkg::NoPair;
        cnt_d  = 8'd0;
        pc_d   = 3'd0;
        pat_d  = 8'd0;
      end
    end

    res_o.valid     = update && done;
    res_o.direction = qed_pkg::decode_pattern(pat_upd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      last_q     <= qed_pkg::PairReset;
      cnt_q      <= 8'd0;
      chg_q      <= 1'b0;
      pc_q       <= 3'd0;
      pat_q      <= 8'd0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      last_q <= last_d;
      cnt_q  <= cnt_d;
      chg_q  <= chg_d;
      pc_q   <= pc_d;
      pat_q  <= pat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) pair_q <= {chan_b_i, chan_a_i};
  end

  // a decode only ever follows three earlier accepted pairs
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> pc_q == 3'd3) else $error("decode without three pairs");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < qed_pkg::PairsPerPattern) else $error("pair count overflow");

  // after a decode the next sample must register as a change
  a_post_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> last_q == qed_pkg::NoPair && !chg_q && pat_q == 8'd0)
    else $error("state not cleared after decode");

endmodule

// ===== src/qed_out_fifo.sv =====
// ----------------------------------------------------------------------------
// qed_out_fifo: two-entry result buffer
// Decouples the result stream from the sample path; full flag is decoded from the registered count.
// ----------------------------------------------------------------------------
module qed_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qed_pkg::qed_res_t res_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic signed [1:0] direction_o
);

  logic signed [1:0] mem_q [qed_pkg::OutDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push        = res_i.valid;
  assign pop         = valid_o && ready_i;
  assign valid_o     = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'(qed_pkg::OutDepth));
  assign direction_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= res_i.direction;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full_o) else $error("result pushed into full buffer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(qed_pkg::OutDepth)) else $error("buffer count out of range");

endmodule

// ===== src/quadrature_encoder_pattern_decoder.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_pattern_decoder: debounced quadrature step decoder
// Debounces A/B samples, collects four accepted pairs, emits a direction.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// s_axis   in   tvalid/tready        tdata[0]=chan_a, tdata[1]=chan_b
// m_axis   out  tvalid/tready        tdata[1:0]=direction (signed)
// cfg      in   cfg_we_i             cfg_addr_i: 0 enable, 1 stable_threshold
//
// Flow: one sample accepted per clock while the result buffer is not full; it
//   lands in the input register at its transfer edge, the state update writes any
//   result from that register into the buffer, whose count drives m_axis_tvalid.
// Reset: enable=1, threshold=2, previous pair "both high", counters clear.
// Stalls: a two-entry result buffer absorbs output backpressure; input stops
//   only once that buffer is full, set by the full flag decoded from its registered count.
// ----------------------------------------------------------------------------
module quadrature_encoder_pattern_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // sample stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] chan_a, [1] chan_b, rest zero
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] direction, rest zero
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i
);

  qed_pkg::qed_cfg_t cfg_q;
  qed_pkg::qed_res_t res;
  logic              full;
  logic signed [1:0] direction;

  // config registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= qed_pkg::EnableReset;
      cfg_q.threshold <= qed_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qed_pkg::CfgEnable:    cfg_q.enable    <= cfg_wdata_i[0];
        qed_pkg::CfgThreshold: cfg_q.threshold <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  qed_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .chan_a_i   (s_axis_tdata[0]),
    .chan_b_i   (s_axis_tdata[1]),
    .out_full_i (full),
    .res_o      (res)
  );

  qed_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (full),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .direction_o (direction)
  );

  assign m_axis_tdata = {6'd0, direction};

endmodule

// ===== sim/quadrature_encoder_pattern_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_pattern_decoder_tb: self-checking bench for the decoder
// Drives encoder samples on the input stream, predicts the debounced pattern
// decode per accepted transfer and checks every direction on the result side.
// ----------------------------------------------------------------------------
module quadrature_encoder_pattern_decoder_tb;

  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 6;      // input register + state update, with margin
  localparam int CycleLimit   = 200000;
  localparam int LongHold     = 150;    // receiver hold-off for the pressure phase
  localparam int PhaseItems   = 65;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of config and debounce state, queue of directions due
  // --------------------------------------------------------------------------
  class dir_scoreboard;
    logic              enable;
    logic [7:0]        threshold;
    logic [2:0]        prev_pair;     // NoPair after a decode matches no sample
    logic [7:0]        run_len;       // equal repeats of prev_pair
    bit                seen_change;
    logic [2:0]        pairs_taken;
    logic [7:0]        shift_pat;     // oldest accepted pair in the high bits
    logic signed [1:0] due_dirs[$];
    int                errors;

    function new();
      enable      = qed_pkg::EnableReset;
      threshold   = qed_pkg::ThresholdReset;
      prev_pair   = qed_pkg::PairReset;
      run_len     = '0;
      seen_change = 1'b0;
      pairs_taken = '0;
      shift_pat   = '0;
      errors      = 0;
    endfunction

    // the eight step patterns: first four turn forward, last four back
    static function logic [7:0] step_pattern(int idx);
      logic [7:0] p;
      case (idx)
        0:       p = 8'h1e;
        1:       p = 8'h78;
        2:       p = 8'he1;
        3:       p = 8'h87;
        4:       p = 8'h4b;
        5:       p = 8'h2c;
        6:       p = 8'hb4;
        default: p = 8'hc2;
      endcase
      return p;
    endfunction

    function logic signed [1:0] classify(logic [7:0] p);
      logic signed [1:0] dir;
      dir = qed_pkg::DirNone;
      for (int i = 0; i < 8; i++) begin
        if (p == step_pattern(i)) dir = (i < 4) ? qed_pkg::DirFwd : qed_pkg::DirBack;
      end
      return dir;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == qed_pkg::CfgEnable) enable = val[0];
      else threshold = val;
    endfunction

    // one accepted sample transfer
    function void note_sample(logic a, logic b);
      logic [2:0] pair;
      pair = {1'b0, b, a};
      if (!enable) return;
      if (pair == prev_pair) begin
        if (run_len != qed_pkg::CountMax) run_len = run_len + 8'd1;
      end else begin
        seen_change = 1'b1;
        run_len     = '0;
      end
      prev_pair = pair;
      if (run_len == threshold && seen_change) begin
        seen_change = 1'b0;
        pairs_taken = pairs_taken + 3'd1;
        shift_pat   = {shift_pat[5:0], pair[1:0]};
        if (pairs_taken == qed_pkg::PairsPerPattern) begin
          due_dirs.push_back(classify(shift_pat));
          // next sample always counts as a change
          prev_pair   = qed_pkg::NoPair;
          run_len     = '0;
          shift_pat   = '0;
          pairs_taken = '0;
        end
      end
    endfunction

    // one accepted result transfer
    function void check_dir(logic signed [1:0] got);
      logic signed [1:0] want;
      if (due_dirs.size() == 0) begin
        $error("direction: result with nothing expected, actual %0d", got);
        errors++;
        return;
      end
      want = due_dirs.pop_front();
      if (got !== want) begin
        $error("direction mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int waiting();
      return due_dirs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       cfg_we_i;
  logic       cfg_addr_i;
  logic [7:0] cfg_wdata_i;

  quadrature_encoder_pattern_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  dir_scoreboard sb;

  int         idle_pct;      // sender idle chance per cycle
  int         stall_pct;     // receiver stall chance per cycle
  int         hold_cycles;   // long receiver hold-off, counted down below
  int         cur_thr;       // threshold as last written, shapes the stimulus
  int         samples_sent;
  int         cycle_cnt;
  logic [1:0] last_sent;     // last pair put on the bus, {b, a}

  // clock and drive init: every input known from time zero
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = qed_pkg::CfgEnable;
    cfg_wdata_i   = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    cur_thr       = int'(qed_pkg::ThresholdReset);
    samples_sent  = 0;
    cycle_cnt     = 0;
    last_sent     = qed_pkg::PairReset[1:0];
    sb            = new();
  end

  always #HalfPeriod clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("quadrature_encoder_pattern_decoder_tb: done, errors");
      $finish;
    end
  end

  // monitor: both streams sampled at the rising edge, pre-update values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_dir(m_axis_tdata[1:0]);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[0], s_axis_tdata[1]);
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks: all called and returning at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic a, input logic b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    last_sent = {b, a};
    @(negedge clk_i);
  endtask

  // four pairs, oldest first; each held long enough to pass the debounce.
  // A pair equal to the previous one needs a short glitch in between to
  // register as a new change. noisy adds random glitches, extra hold and,
  // now and then, a hold one short of the threshold (a broken step).
  task automatic send_pattern(input logic [7:0] p, input bit noisy);
    logic [1:0] pr;
    logic [1:0] glitch;
    int         hold;
    for (int k = 3; k >= 0; k--) begin
      pr = p[2*k +: 2];
      if (cur_thr > 0 && (pr == last_sent || (noisy && $urandom_range(99) < 25))) begin
        glitch = pr ^ 2'($urandom_range(1, 3));
        repeat (noisy ? $urandom_range(1, (cur_thr < 4) ? cur_thr : 4) : 1)
          send_sample(glitch[0], glitch[1]);
      end
      hold = cur_thr + 1;
      if (noisy) begin
        hold += $urandom_range(0, 2);
        if ($urandom_range(99) < 5) hold = cur_thr;
      end
      repeat (hold) send_sample(pr[0], pr[1]);
    end
  endtask

  // mostly step sequences with random content, the rest raw noise
  task automatic random_burst();
    logic [7:0] p;
    if ($urandom_range(99) < 80) begin
      p = ($urandom_range(99) < 60) ? dir_scoreboard::step_pattern($urandom_range(7))
                                    : 8'($urandom_range(255));
      send_pattern(p, 1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // stop sending and wait until every due direction has been seen
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    if (idx == qed_pkg::CfgThreshold) cur_thr = int'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset config: forward step, then a back step whose middle
    // pairs repeat (needs a glitch)
    send_pattern(8'h1e, 1'b0);
    send_pattern(8'hc2, 1'b0);
    settle();
    // zero threshold: accepted on the tick of the change; then an invalid one
    write_reg(qed_pkg::CfgThreshold, 8'd0);
    send_pattern(8'h4b, 1'b0);
    send_pattern(8'h9c, 1'b0);
    settle();

    // disabled: samples leave the state alone; upper data bits ignored
    write_reg(qed_pkg::CfgEnable, 8'hfe);
    repeat (8) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
    settle();
    write_reg(qed_pkg::CfgEnable, 8'h81);

    // random phases across the idling modes, two thresholds each
    for (int m = 0; m < 4; m++) begin
      case (m)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 62; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int k = 0; k < 2; k++) begin
        settle();
        write_reg(qed_pkg::CfgThreshold, 8'($urandom_range(0, (k == 0) ? 3 : 6)));
        target = samples_sent + PhaseItems;
        while (samples_sent < target) random_burst();
      end
    end

    // long threshold: a single slow step with long repeat runs
    idle_pct  = 0;
    stall_pct = 0;
    settle();
    write_reg(qed_pkg::CfgThreshold, 8'd24);
    send_pattern(dir_scoreboard::step_pattern($urandom_range(7)), 1'b1);
    settle();

    // backpressure: receiver holds off while steps keep coming
    write_reg(qed_pkg::CfgThreshold, 8'd0);
    hold_cycles = LongHold;
    repeat (15) send_pattern(dir_scoreboard::step_pattern($urandom_range(7)), 1'b0);

    // short random tail at the reset threshold
    settle();
    write_reg(qed_pkg::CfgThreshold, qed_pkg::ThresholdReset);
    idle_pct  = 19;
    stall_pct = 19;
    target = samples_sent + 60;
    while (samples_sent < target) random_burst();

    settle();
    if (sb.errors == 0) begin
      $display("quadrature_encoder_pattern_decoder_tb: done, clean");
    end else begin
      $display("quadrature_encoder_pattern_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
